### hdl/text_console_writer_defines.svh
// Assertion macros shared by the console RTL.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tcw_pkg.sv
// Constants, command codes and state encoding of the text console writer.
package tcw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int SHIFT_CELLS = COLUMNS * (ROWS - 1);
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int ROW_W       = $clog2(ROWS);

    localparam logic [7:0]  CH_NL      = 8'h0A;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [7:0]  CH_BS      = 8'h08;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_PR_LAST = 8'h7F;
    localparam logic [7:0]  ATTR_RESET = 8'h07;
    localparam logic [15:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

    typedef enum logic [1:0] {
        CMD_PRINT = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_EXEC   = 8'b0000_0100,
        ST_READ   = 8'b0000_1000,
        ST_FILL   = 8'b0001_0000,
        ST_SCROLL = 8'b0010_0000,
        ST_BLANK  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } t_state;

endpackage

### hdl/text_console_writer.sv
// Text console writer: screen buffer in one RAM, cursor and command sequencer.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_stall  | i_command, i_char_code, i_cell_index
//  output   | o_out_valid / i_out_stall| o_cursor_col, o_cursor_line, o_did_scroll,
//           |                          | o_cell_value
//  config   | i_cfg_we                 | i_cfg_wdata (text attribute)
//
// One item at a time through a single-port-write, single-port-read cell RAM.
// Print runs ST_EXEC then ST_DONE to the result register; read adds ST_READ;
// clear adds ST_FILL (one cell written per cycle). A print that scrolls adds
// ST_SCROLL and ST_BLANK: the row copy streams one cell a cycle, then the
// last row is blanked. After reset the RAM is swept to blank with o_in_stall
// high. A result waiting on i_out_stall does not block the next transfer in;
// it holds the sequencer only when the next result is due.
`include "text_console_writer_defines.svh"

module text_console_writer
    import tcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_line,
    output logic        o_did_scroll,
    output logic [15:0] o_cell_value,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    logic [15:0] r_mem [CELL_COUNT];
    logic [15:0] r_rd_data;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_ptr, n_ptr;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic               r_scroll, n_scroll;
    logic [15:0]        r_value, n_value;
    logic               r_wr_pend, n_wr_pend;
    logic [ADDR_W-1:0]  r_wr_addr, n_wr_addr;
    logic [7:0]         r_attr;
    logic [1:0]         r_cmd;
    logic [7:0]         r_char;
    logic [10:0]        r_index;
    logic               r_out_valid;
    logic [6:0]         r_out_col;
    logic [4:0]         r_out_row;
    logic               r_out_scroll;
    logic [15:0]        r_out_value;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [15:0]        mem_wd;
    logic [ADDR_W-1:0]  mem_ra;

    logic               in_xfer;
    logic               out_load;
    logic [15:0]        blank_cell;
    logic               idx_ok;
    logic [ADDR_W-1:0]  cur_addr;
    logic [COL_W:0]     col_t;
    logic [ROW_W:0]     row_t;
    logic               pr_we;
    logic [ADDR_W-1:0]  pr_addr;
    logic [15:0]        pr_data;
    logic               pr_scroll;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    assign blank_cell = {r_attr, CH_SPACE};
    assign idx_ok     = ({21'd0, r_index} < 32'(CELL_COUNT));
    assign cur_addr   = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);

    // Cursor motion and cell write of one printed byte.
    always_comb begin
        col_t     = {1'b0, r_col};
        row_t     = {1'b0, r_row};
        pr_we     = 1'b0;
        pr_addr   = cur_addr;
        pr_data   = blank_cell;
        pr_scroll = 1'b0;
        case (r_char)
            CH_NL: begin
                col_t = '0;
                row_t = row_t + 1'b1;
            end
            CH_CR: begin
                col_t = '0;
            end
            CH_BS: begin
                if (r_col != '0) begin
                    col_t   = col_t - 1'b1;
                    pr_we   = 1'b1;
                    pr_addr = cur_addr - 1'b1;
                end
            end
            default: begin
                if (r_char >= CH_SPACE && r_char <= CH_PR_LAST) begin
                    pr_we   = 1'b1;
                    pr_data = {r_attr, r_char};
                    col_t   = col_t + 1'b1;
                end
            end
        endcase
        if (32'(col_t) >= COLUMNS) begin
            col_t = '0;
            row_t = row_t + 1'b1;
        end
        if (32'(row_t) >= ROWS) begin
            pr_scroll = 1'b1;
            row_t     = (ROW_W + 1)'(ROWS - 1);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_col     = r_col;
        n_row     = r_row;
        n_scroll  = r_scroll;
        n_value   = r_value;
        n_wr_pend = 1'b0;
        n_wr_addr = r_ptr;
        mem_we    = 1'b0;
        mem_wa    = r_ptr;
        mem_wd    = blank_cell;
        mem_ra    = r_ptr + ADDR_W'(COLUMNS);
        // Finish the copy of the cell read in the previous cycle.
        if (r_wr_pend) begin
            mem_we = 1'b1;
            mem_wa = r_wr_addr;
            mem_wd = r_rd_data;
        end
        case (r_state)
            ST_INIT: begin
                mem_we = 1'b1;
                mem_wd = CELL_RESET;
                if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_ptr   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_scroll = 1'b0;
                n_value  = '0;
                case (r_cmd)
                    CMD_PRINT: begin
                        mem_we = pr_we;
                        mem_wa = pr_addr;
                        mem_wd = pr_data;
                        n_col  = col_t[COL_W-1:0];
                        n_row  = row_t[ROW_W-1:0];
                        if (pr_scroll) begin
                            n_scroll = 1'b1;
                            n_ptr    = '0;
                            n_state  = ST_SCROLL;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    CMD_CLEAR: begin
                        n_col   = '0;
                        n_row   = '0;
                        n_ptr   = '0;
                        n_state = ST_FILL;
                    end
                    CMD_READ: begin
                        mem_ra  = ADDR_W'(r_index);
                        n_state = ST_READ;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_READ: begin
                n_value = idx_ok ? r_rd_data : 16'd0;
                n_state = ST_DONE;
            end
            ST_FILL: begin
                mem_we = 1'b1;
                if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_SCROLL: begin
                // Read one row ahead, write back in the next cycle.
                n_wr_pend = 1'b1;
                n_wr_addr = r_ptr;
                if (r_ptr == ADDR_W'(SHIFT_CELLS - 1)) begin
                    n_ptr   = ADDR_W'(SHIFT_CELLS);
                    n_state = ST_BLANK;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_BLANK: begin
                if (!r_wr_pend) begin
                    mem_we = 1'b1;
                    if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_ptr       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_wr_pend   <= 1'b0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_col     <= n_col;
            r_row     <= n_row;
            r_wr_pend <= n_wr_pend;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scroll  <= n_scroll;
        r_value   <= n_value;
        r_wr_addr <= n_wr_addr;
        if (in_xfer) begin
            r_cmd   <= i_command;
            r_char  <= i_char_code;
            r_index <= i_cell_index;
        end
        if (out_load) begin
            r_out_col    <= 7'(r_col);
            r_out_row    <= 5'(r_row);
            r_out_scroll <= r_scroll;
            r_out_value  <= r_value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cursor_col  = r_out_col;
    assign o_cursor_line = r_out_row;
    assign o_did_scroll  = r_out_scroll;
    assign o_cell_value  = r_out_value;

    `TCW_ASSERT_NOW(a_cursor_range, 1'b1,
        (32'(r_col) < COLUMNS) && (32'(r_row) < ROWS), "cursor left the screen")
    `TCW_ASSERT_NEXT(a_xfer_exec, in_xfer, r_state == ST_EXEC,
        "accepted transfer not executed")
    `TCW_ASSERT_NOW(a_pend_scroll, r_wr_pend,
        (r_state == ST_SCROLL) || (r_state == ST_BLANK), "stray copy write")
    `TCW_ASSERT_NOW(a_scroll_ptr, r_state == ST_SCROLL,
        32'(r_ptr) < SHIFT_CELLS, "scroll copy past the last row")
    `TCW_ASSERT_NOW(a_scroll_row, r_out_valid && r_out_scroll,
        r_out_row == 5'(ROWS - 1), "scroll did not leave cursor on last row")

endmodule

### test/text_console_writer_tb.sv
// Self-checking testbench for the text console writer: predictor, stimulus and report checker.
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         MAX_INDEX  = 2047;
    localparam int         HOLD_LEN   = 600;
    localparam int         SETTLE     = 8;
    localparam int         TAIL       = 2100;
    localparam longint     LIMIT_TIME = 400_000_000;

    typedef struct packed {
        logic [6:0]  col;
        logic [4:0]  line;
        logic        scrolled;
        logic [15:0] cell_word;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_command = CMD_PRINT;
    logic [7:0]  i_char_code = '0;
    logic [10:0] i_cell_index = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [6:0]  o_cursor_col;
    logic [4:0]  o_cursor_line;
    logic        o_did_scroll;
    logic [15:0] o_cell_value;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;

    // Shadow of the console state
    logic [15:0] shadow_screen [CELL_COUNT];
    int unsigned shadow_col;
    int unsigned shadow_row;
    logic [7:0]  shadow_attr;

    t_report     cursor_reports [$];
    int          bad_reports = 0;
    int          reports_seen = 0;
    int          items_sent = 0;
    bit          gaps_on = 1'b0;
    int          hold_request = 0;
    int          hold_left = 0;
    int          stall_left = 0;

    text_console_writer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_char_code   (i_char_code),
        .i_cell_index  (i_cell_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cursor_col  (o_cursor_col),
        .o_cursor_line (o_cursor_line),
        .o_did_scroll  (o_did_scroll),
        .o_cell_value  (o_cell_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    function automatic bit print_char(logic [7:0] ch);
        if (ch == CH_NL) begin
            shadow_col = 0;
            shadow_row++;
        end else if (ch == CH_CR) begin
            shadow_col = 0;
        end else if (ch == CH_BS) begin
            if (shadow_col > 0) begin
                shadow_col--;
                shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, CH_SPACE};
            end
        end else if (ch >= CH_SPACE && ch <= CH_PR_LAST) begin
            shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, ch};
            shadow_col++;
        end
        if (shadow_col >= COLUMNS) begin
            shadow_col = 0;
            shadow_row++;
        end
        if (shadow_row >= ROWS) begin
            for (int i = 0; i < SHIFT_CELLS; i++)
                shadow_screen[i] = shadow_screen[i + COLUMNS];
            for (int i = SHIFT_CELLS; i < CELL_COUNT; i++)
                shadow_screen[i] = {shadow_attr, CH_SPACE};
            shadow_row = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_report console_step(logic [1:0] cmd, logic [7:0] ch, logic [10:0] idx);
        t_report rep;
        rep.scrolled = 1'b0;
        rep.cell_word = '0;
        case (cmd)
            CMD_PRINT: rep.scrolled = print_char(ch);
            CMD_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++)
                    shadow_screen[i] = {shadow_attr, CH_SPACE};
                shadow_col = 0;
                shadow_row = 0;
            end
            CMD_READ: begin
                if (idx < CELL_COUNT)
                    rep.cell_word = shadow_screen[idx];
            end
            default: ;
        endcase
        rep.col = shadow_col[6:0];
        rep.line = shadow_row[4:0];
        return rep;
    endfunction

    // Mostly cells on or just above the cursor row, some anywhere, a few past the end
    function automatic logic [10:0] read_target();
        int r;
        int unsigned row;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            row = (shadow_row > 0 && $urandom_range(0, 1)) ? shadow_row - 1 : shadow_row;
            return 11'(row * COLUMNS + $urandom_range(0, COLUMNS - 1));
        end else if (r < 9) begin
            return 11'($urandom_range(0, CELL_COUNT - 1));
        end
        return 11'($urandom_range(CELL_COUNT, MAX_INDEX));
    endfunction

    task automatic send_item(logic [1:0] cmd, logic [7:0] ch, logic [10:0] idx);
        int gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_char_code <= ch;
        i_cell_index <= idx;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        cursor_reports.push_back(console_step(cmd, ch, idx));
        items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (cursor_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_attribute(logic [7:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_attr = value;
    endtask

    task automatic test_reset_contents();
        gaps_on = 1'b0;
        send_item(CMD_READ, 8'h00, 11'd0);
        send_item(CMD_READ, 8'hFF, 11'(CELL_COUNT - 1));
        send_item(CMD_READ, 8'h00, 11'(CELL_COUNT));
        send_item(CMD_READ, 8'hFF, 11'(MAX_INDEX));
        send_item(CMD_UNUSED, 8'hFF, 11'(MAX_INDEX));
        wait_idle();
    endtask

    task automatic test_print_cases();
        gaps_on = 1'b0;
        send_item(CMD_PRINT, 8'h41, 11'd0);
        send_item(CMD_PRINT, CH_SPACE, 11'd0);
        send_item(CMD_PRINT, CH_PR_LAST, 11'(MAX_INDEX));
        // ignored bytes: low controls and the upper half
        send_item(CMD_PRINT, 8'h00, 11'd0);
        send_item(CMD_PRINT, 8'h1F, 11'd0);
        send_item(CMD_PRINT, 8'h09, 11'd0);
        send_item(CMD_PRINT, 8'h80, 11'd0);
        send_item(CMD_PRINT, 8'hFF, 11'd0);
        send_item(CMD_PRINT, CH_BS, 11'd0);
        send_item(CMD_READ, 8'h00, 11'd2);
        send_item(CMD_READ, 8'h00, 11'd0);
        send_item(CMD_PRINT, CH_CR, 11'd0);
        // backspace at column zero does nothing
        send_item(CMD_PRINT, CH_BS, 11'd0);
        send_item(CMD_PRINT, CH_NL, 11'd0);
        send_item(CMD_PRINT, 8'h7E, 11'd0);
        send_item(CMD_READ, 8'h00, 11'(COLUMNS));
        send_item(CMD_UNUSED, 8'h00, 11'd0);
        send_item(CMD_CLEAR, 8'hFF, 11'(MAX_INDEX));
        send_item(CMD_READ, 8'h00, 11'(COLUMNS));
        wait_idle();
    endtask

    task automatic send_text_line();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 80)
            len = $urandom_range(0, 10);
        else if (r < 95)
            len = $urandom_range(11, 79);
        else
            len = $urandom_range(80, 170);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 4) == 0)
                send_item(CMD_READ, 8'($urandom_range(0, 255)), read_target());
            if ($urandom_range(0, 14) == 0)
                send_item(CMD_PRINT, CH_BS, 11'($urandom_range(0, MAX_INDEX)));
            else
                send_item(CMD_PRINT, 8'($urandom_range(CH_SPACE, CH_PR_LAST)),
                          11'($urandom_range(0, MAX_INDEX)));
        end
        if ($urandom_range(0, 9) == 0)
            send_item(CMD_PRINT, CH_CR, 11'($urandom_range(0, MAX_INDEX)));
        send_item(CMD_PRINT, CH_NL, 11'($urandom_range(0, MAX_INDEX)));
    endtask

    task automatic test_text_lines(int phases, int per_phase);
        int phase_end;
        for (int p = 0; p < phases; p++) begin
            if (p == 0)
                set_attribute(8'h00);
            else if (p == 1)
                set_attribute(8'hFF);
            else
                set_attribute(8'($urandom_range(0, 255)));
            // every third phase runs back to back
            gaps_on = (p % 3 != 2);
            phase_end = items_sent + per_phase;
            while (items_sent < phase_end)
                send_text_line();
            wait_idle();
        end
    endtask

    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        hold_request = HOLD_LEN;
        repeat (40) begin
            if ($urandom_range(0, 1))
                send_item(CMD_READ, 8'($urandom_range(0, 255)), read_target());
            else
                send_item(CMD_PRINT, 8'($urandom_range(CH_SPACE, CH_PR_LAST)),
                          11'($urandom_range(0, MAX_INDEX)));
        end
        wait_idle();
    endtask

    task automatic test_noise(int count);
        int r;
        logic [1:0] cmd;
        gaps_on = 1'b1;
        set_attribute(ATTR_RESET);
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                cmd = CMD_PRINT;
            else if (r < 52)
                cmd = CMD_CLEAR;
            else if (r < 92)
                cmd = CMD_READ;
            else
                cmd = CMD_UNUSED;
            send_item(cmd, 8'($urandom_range(0, 255)), 11'($urandom_range(0, MAX_INDEX)));
        end
        wait_idle();
    endtask

    // Output side: random stall runs, plus a long hold on request
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            if (gaps_on && $urandom_range(0, 3) == 0)
                stall_left = idle_len();
        end
    end

    always @(posedge i_clk) begin : check_reports
        t_report want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            reports_seen++;
            if (cursor_reports.size() == 0) begin
                bad_reports++;
                if (bad_reports <= 10)
                    $display({"report %0d arrived with nothing pending: ",
                              "col %0d row %0d scroll %0b cell %h"},
                             reports_seen, o_cursor_col, o_cursor_line, o_did_scroll,
                             o_cell_value);
            end else begin
                want = cursor_reports.pop_front();
                if (o_cursor_col !== want.col || o_cursor_line !== want.line ||
                    o_did_scroll !== want.scrolled || o_cell_value !== want.cell_word) begin
                    bad_reports++;
                    if (bad_reports <= 10)
                        $display({"report %0d: want col %0d row %0d scroll %0b cell %h, ",
                                  "got col %0d row %0d scroll %0b cell %h"},
                                 reports_seen, want.col, want.line, want.scrolled,
                                 want.cell_word, o_cursor_col, o_cursor_line,
                                 o_did_scroll, o_cell_value);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < CELL_COUNT; i++)
            shadow_screen[i] = CELL_RESET;
        shadow_col = 0;
        shadow_row = 0;
        shadow_attr = ATTR_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_contents();
        test_print_cases();
        test_text_lines(9, 100);
        test_output_backpressure();
        test_noise(340);
        repeat (TAIL) @(posedge i_clk);
        if (bad_reports == 0 && cursor_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #(LIMIT_TIME);
        $display("Mismatches found");
        $finish;
    end

endmodule
